/* src/lsfx_pkg.sv */
package lsfx_pkg;

	// Default build constants
	localparam int LED_COUNT_DEF   = 16;
	localparam int FRAME_MS_DEF    = 16;
	localparam int BURST_MS_DEF    = 10;
	localparam int TAIL_LENGTH_DEF = 5;

	// Fixed field widths
	localparam int IDX_W   = 6;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 24;
	localparam int FCD_W   = 5;
	localparam int BCD_W   = 4;
	localparam int HEAD_W  = 7;
	localparam int PHASE_W = 16;
	localparam int FACT_W  = 17;

	localparam logic [PHASE_W-1:0] PHASE_STEP = 16'd209;
	localparam logic [HEAD_W-1:0]  HEAD_OFF   = 7'h7F;

	// Register indexes (by paddr[2])
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COLOR = 1'b1;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_STATIC = 2'd1,
		MODE_BREATH = 2'd2,
		MODE_BURST  = 2'd3
	} mode_t;

	// Controller to datapath
	typedef struct packed {
		logic tick_step;
		logic pix_load;
	} lsfx_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_due;
		logic last_pix;
	} lsfx_stat_t;

	// round(128*sin(2*pi*k/256)), k = 0..64
	localparam logic [7:0] QSINE [0:64] = '{
		8'd0,   8'd3,   8'd6,   8'd9,   8'd13,  8'd16,  8'd19,  8'd22,
		8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
		8'd49,  8'd52,  8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,
		8'd71,  8'd74,  8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,
		8'd91,  8'd93,  8'd95,  8'd97,  8'd99,  8'd101, 8'd103, 8'd105,
		8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
		8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
		8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
		8'd128
	};

	// Q0.8 brightness (sin+1)/2 from the upper phase byte, saturated
	function automatic logic [7:0] brightness(input logic [PHASE_W-1:0] phase);
		logic [7:0] idx;
		logic [6:0] q;
		logic [7:0] s;
		logic [8:0] v;
		idx = phase[15:8];
		q = {1'b0, idx[5:0]};
		s = idx[6] ? QSINE[7'd64 - q] : QSINE[q];
		v = idx[7] ? (9'd128 - {1'b0, s}) : (9'd128 + {1'b0, s});
		return v[8] ? 8'hFF : v[7:0];
	endfunction

	// ceil(2^16/(d+1)); (c*r)>>16 equals c/(d+1) exactly for 8-bit c
	function automatic logic [FACT_W-1:0] recip(input logic [2:0] d);
		logic [FACT_W-1:0] r;
		unique case (d)
			3'd0: r = 17'd65536;
			3'd1: r = 17'd32768;
			3'd2: r = 17'd21846;
			3'd3: r = 17'd16384;
			3'd4: r = 17'd13108;
			3'd5: r = 17'd10923;
			3'd6: r = 17'd9363;
			default: r = 17'd8192;
		endcase
		return r;
	endfunction

endpackage

/* src/lsfx_ctrl.sv */
module lsfx_ctrl import lsfx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_tick,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  lsfx_stat_t stat,
	output lsfx_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands
	always_comb begin
		cmd.tick_step = in_ready && in_valid && in_tick;
		cmd.pix_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.tick_step && stat.frame_due) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.pix_load && stat.last_pix) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.pix_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/lsfx_datapath.sv */
module lsfx_datapath import lsfx_pkg::*; #(
	parameter int LED_COUNT   = LED_COUNT_DEF,
	parameter int FRAME_MS    = FRAME_MS_DEF,
	parameter int BURST_MS    = BURST_MS_DEF,
	parameter int TAIL_LENGTH = TAIL_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsfx_cmd_t          cmd,
	output lsfx_stat_t         stat,
	input  logic               cfg_wr,
	input  mode_t              mode,
	input  logic [COLOR_W-1:0] color,
	output logic [IDX_W-1:0]   pix_index,
	output logic [CHAN_W-1:0]  red,
	output logic [CHAN_W-1:0]  green,
	output logic [CHAN_W-1:0]  blue,
	output logic               last_pixel
);

	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(LED_COUNT - 1);
	localparam logic [HEAD_W:0]   LED_CNT_W = (HEAD_W + 1)'(LED_COUNT);
	localparam logic [HEAD_W-1:0] TAIL_LEN  = HEAD_W'(TAIL_LENGTH);
	localparam logic [FCD_W-1:0]  FCD_LOAD  = FCD_W'(FRAME_MS - 1);
	localparam logic [BCD_W-1:0]  BCD_LOAD  = BCD_W'(BURST_MS);

	logic [FCD_W-1:0]   fcd_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [PHASE_W-1:0] phase_q;
	logic [HEAD_W-1:0]  head_q;
	logic [7:0]         bright_q;
	logic [IDX_W-1:0]   pix_q;

	logic               frame_due;
	logic               move_due;
	logic [HEAD_W-1:0]  head_next;
	logic [HEAD_W-1:0]  tail_ofs;
	logic [FACT_W-1:0]  factor;
	logic [24:0]        prod_r, prod_g, prod_b;

	assign frame_due = (fcd_q == '0);
	// countdown after this tick's decrement is zero
	assign move_due  = (bcd_q == BCD_W'(0)) || (bcd_q == BCD_W'(1));

	always_comb begin
		stat.frame_due = frame_due;
		stat.last_pix  = (pix_q == LAST_IDX);
	end

	// Head advance with wrap at the end of the strip
	always_comb begin
		if (head_q == HEAD_OFF || ({1'b0, head_q} + 8'd1) >= LED_CNT_W) begin
			head_next = '0;
		end else begin
			head_next = head_q + HEAD_W'(1);
		end
	end

	// Frame timing and effect state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcd_q   <= '0;
			bcd_q   <= '0;
			phase_q <= '0;
			head_q  <= HEAD_OFF;
			pix_q   <= '0;
		end else if (cfg_wr) begin
			bcd_q   <= '0;
			phase_q <= '0;
			head_q  <= HEAD_OFF;
		end else if (cmd.tick_step) begin
			if (bcd_q != '0) bcd_q <= bcd_q - BCD_W'(1);
			if (!frame_due) begin
				fcd_q <= fcd_q - FCD_W'(1);
			end else begin
				fcd_q <= FCD_LOAD;
				pix_q <= '0;
				if (mode == MODE_BREATH) phase_q <= phase_q + PHASE_STEP;
				if (mode == MODE_BURST && move_due) begin
					head_q <= head_next;
					bcd_q  <= BCD_LOAD;
				end
			end
		end else if (cmd.pix_load) begin
			pix_q <= pix_q + IDX_W'(1);
		end
	end

	// Brightness for the frame, held while it is emitted
	always_ff @(posedge clk) begin
		if (cmd.tick_step && frame_due) bright_q <= brightness(phase_q);
	end

	// Per-pixel scale factor, Q1.16
	assign tail_ofs = head_q - {1'b0, pix_q};

	always_comb begin
		factor = '0;
		unique case (mode)
			MODE_OFF:    factor = '0;
			MODE_STATIC: factor = 17'h10000;
			MODE_BREATH: factor = {1'b0, bright_q, 8'h00};
			MODE_BURST: begin
				if (head_q != HEAD_OFF && head_q >= {1'b0, pix_q} && tail_ofs < TAIL_LEN)
					factor = recip(tail_ofs[2:0]);
			end
		endcase
	end

	assign prod_r = {17'd0, color[15:8]}  * {8'd0, factor};
	assign prod_g = {17'd0, color[23:16]} * {8'd0, factor};
	assign prod_b = {17'd0, color[7:0]}   * {8'd0, factor};

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.pix_load) begin
			pix_index  <= pix_q;
			red        <= prod_r[23:16];
			green      <= prod_g[23:16];
			blue       <= prod_b[23:16];
			last_pixel <= (pix_q == LAST_IDX);
		end
	end

endmodule

/* src/led_strip_effect_generator.sv */
// A tick item that starts a frame moves the controller to ST_EMIT; pixel 0 then goes into the output register.
// Throughput: a frame is LED_COUNT pixel items, one per cycle while m_tready is high, paced
// by the pixel counter of the datapath; no tick item is taken while a frame is emitted, and
// a tick that renders nothing leaves the block ready for the next tick item.
// Reset: arst_n clears mode, color, countdowns, phase and burst head (off strip) at once;
// the first tick after reset renders a frame.
module led_strip_effect_generator import lsfx_pkg::*; #(
	parameter int LED_COUNT   = LED_COUNT_DEF,
	parameter int FRAME_MS    = FRAME_MS_DEF,
	parameter int BURST_MS    = BURST_MS_DEF,
	parameter int TAIL_LENGTH = TAIL_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [5:0] pixel_index, [13:6] red, [21:14] green, [29:22] blue
	output logic        m_tlast,   // last_pixel
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mode_t              mode_q;
	logic [COLOR_W-1:0] color_q;
	logic               cfg_wr;
	lsfx_cmd_t          cmd;
	lsfx_stat_t         stat;
	logic [IDX_W-1:0]   pix_index;
	logic [CHAN_W-1:0]  red, green, blue;

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_OFF;
			color_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MODE) begin
				mode_q <= mode_t'(pwdata[1:0]);
			end else begin
				color_q <= pwdata[COLOR_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_q} : {8'd0, color_q};

	lsfx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_tick   (s_tdata[0]),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lsfx_datapath #(
		.LED_COUNT   (LED_COUNT),
		.FRAME_MS    (FRAME_MS),
		.BURST_MS    (BURST_MS),
		.TAIL_LENGTH (TAIL_LENGTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_wr     (cfg_wr),
		.mode       (mode_q),
		.color      (color_q),
		.pix_index  (pix_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (m_tlast)
	);

	assign m_tdata = {2'b00, blue, green, red, pix_index};

	// last flag marks exactly the final strip position
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[5:0] == IDX_W'(LED_COUNT - 1))))
		else $error("last flag does not match pixel index");

	// inside a frame the next pixel follows without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a frame");

	// while taking ticks, only the final pixel of a frame may still wait
	a_idle_tail: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("tick taken with a frame still in progress");

endmodule
